### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define BF3_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Plain condition checked at every rising edge outside reset.
`define BF3_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

### rtl/bf3_pkg.sv
// ----------------------------------------------------------------------------
// bf3_pkg
// Shared types and constants of the 3x3 box filter.
// ----------------------------------------------------------------------------
package bf3_pkg;

    localparam int MAX_COLS  = 1024;
    localparam int MAX_ROWS  = 1024;
    localparam int PIX_W     = 8;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int SIZE_W    = 11;
    localparam int QDEPTH    = 4;
    localparam int QCNT_W    = $clog2(QDEPTH + 1);
    localparam int SUM_W     = PIX_W + 4;
    localparam int RECIP_W   = 13;
    localparam int RECIP_SH  = 16;
    // ceil(2^16 / 9): exact truncated quotient for sums below 2^12
    localparam logic [RECIP_W-1:0] RECIP9 = 13'd7282;
    localparam logic [PIX_W-1:0]   MIN_START_RESET = 8'd64;

    typedef enum logic [1:0]
    {
        REG_NUM_ROWS  = 2'd0,
        REG_NUM_COLS  = 2'd1,
        REG_MIN_START = 2'd2,
        REG_NONE      = 2'd3
    } bf3_reg_t;

    // One classified item handed from the front to the back.
    typedef struct packed
    {
        logic              fetch;    // read line buffers, update window
        logic              wr;       // write the pixel into the line buffers
        logic              use_pix;  // bottom row comes from the pixel
        logic              top_mid;  // first result row: top copies middle
        logic              emit_j0;  // column 0 also closes the previous row
        logic              tail;     // final result of the frame
        logic              fs;       // frame start: restart min/max
        logic [COL_W-1:0]  col;
        logic [PIX_W-1:0]  pix;
        logic [PIX_W-1:0]  min_start;
    } bf3_cmd_t;

endpackage

### rtl/bf3_front.sv
// ----------------------------------------------------------------------------
// bf3_front
// Frame sequencer: counts rows, columns and drains, classifies each beat.
// ----------------------------------------------------------------------------
module bf3_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [bf3_pkg::PIX_W-1:0]     pixel_value,
    input  logic                          drain,
    input  logic                          abandon,
    input  logic [bf3_pkg::SIZE_W-1:0]    num_rows,
    input  logic [bf3_pkg::SIZE_W-1:0]    num_cols,
    input  logic [bf3_pkg::PIX_W-1:0]     min_start,
    output logic                          push,
    output bf3_pkg::bf3_cmd_t             cmd
);
    import bf3_pkg::*;

    typedef enum logic [1:0]
    {
        PH_PIX,
        PH_DRAIN,
        PH_TAIL
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [SIZE_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [SIZE_W-1:0]   drn_reg, drn_next;
    logic [SIZE_W-1:0]   rows, cols, row_e, row_inc, col_inc, drn_inc;
    logic [COL_W-1:0]    col_e;

    always_comb
    begin
        rows = (num_rows == '0) ? SIZE_W'(1)
             : (num_rows > SIZE_W'(MAX_ROWS)) ? SIZE_W'(MAX_ROWS) : num_rows;
        cols = (num_cols == '0) ? SIZE_W'(1)
             : (num_cols > SIZE_W'(MAX_COLS)) ? SIZE_W'(MAX_COLS) : num_cols;
    end

    always_comb
    begin
        // a pixel after the frame's pixels starts over
        row_e   = (phase_reg != PH_PIX) ? '0 : row_reg;
        col_e   = (phase_reg != PH_PIX) ? '0 : col_reg;
        row_inc = row_e + SIZE_W'(1);
        col_inc = SIZE_W'(col_e) + SIZE_W'(1);
        drn_inc = drn_reg + SIZE_W'(1);

        phase_next = phase_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        drn_next   = drn_reg;
        push       = 1'b0;
        cmd        = '0;
        cmd.pix       = pixel_value;
        cmd.min_start = min_start;

        if (abandon)
        begin
            phase_next = PH_PIX;
            row_next   = '0;
            col_next   = '0;
            drn_next   = '0;
        end
        else if (accept && !drain)
        begin
            push        = 1'b1;
            cmd.fetch   = (row_e != '0);
            cmd.wr      = 1'b1;
            cmd.use_pix = 1'b1;
            cmd.top_mid = (row_e == SIZE_W'(1));
            cmd.emit_j0 = (row_e >= SIZE_W'(2));
            cmd.fs      = (row_e == '0) && (col_e == '0);
            cmd.col     = col_e;
            phase_next  = PH_PIX;
            drn_next    = '0;
            if (col_inc >= cols)
            begin
                col_next = '0;
                row_next = row_inc;
                if (row_inc >= rows)
                begin
                    phase_next = PH_DRAIN;
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
                row_next = row_e;
            end
        end
        else if (accept)
        begin
            unique case (phase_reg)
                PH_DRAIN:
                begin
                    push        = 1'b1;
                    cmd.fetch   = 1'b1;
                    cmd.top_mid = (rows == SIZE_W'(1));
                    cmd.emit_j0 = (rows >= SIZE_W'(2));
                    cmd.col     = drn_reg[COL_W-1:0];
                    drn_next    = drn_inc;
                    if (drn_inc >= cols)
                    begin
                        phase_next = PH_TAIL;
                    end
                end
                PH_TAIL:
                begin
                    push       = 1'b1;
                    cmd.tail   = 1'b1;
                    phase_next = PH_PIX;
                    row_next   = '0;
                    col_next   = '0;
                    drn_next   = '0;
                end
                default:
                begin
                    // early drain: drop it
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PIX;
            row_reg   <= '0;
            col_reg   <= '0;
            drn_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            drn_reg   <= drn_next;
        end
    end

endmodule

### rtl/bf3_queue.sv
// ----------------------------------------------------------------------------
// bf3_queue
// Short command queue between the sequencer and the datapath.
// ----------------------------------------------------------------------------
module bf3_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  bf3_pkg::bf3_cmd_t             push_cmd,
    input  logic                          pop,
    output logic                          empty,
    output logic                          full,
    output logic [bf3_pkg::QCNT_W-1:0]    level,
    output bf3_pkg::bf3_cmd_t             head
);
    import bf3_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);

    bf3_cmd_t            slot_reg [QDEPTH];
    logic [PTR_W-1:0]    rd_reg, wr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push, do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign level   = cnt_reg;
    assign head    = slot_reg[rd_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= wr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_reg <= rd_reg + PTR_W'(1);
            end
            cnt_reg <= cnt_reg + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

### rtl/bf3_back.sv
// ----------------------------------------------------------------------------
// bf3_back
// Datapath: line buffers, 3x3 window, sum, divide by nine, min/max, output.
// ----------------------------------------------------------------------------
module bf3_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  bf3_pkg::bf3_cmd_t             q_head,
    output logic                          q_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bf3_pkg::PIX_W-1:0]     mean_value,
    output logic [bf3_pkg::PIX_W-1:0]     frame_min,
    output logic [bf3_pkg::PIX_W-1:0]     frame_max,
    output logic                          frame_last
);
    import bf3_pkg::*;

    logic [PIX_W-1:0] lb_a [MAX_COLS];
    logic [PIX_W-1:0] lb_b [MAX_COLS];

    logic                adv;

    // stage 1: line buffer read
    logic                s1_valid_reg;
    bf3_cmd_t            s1_cmd_reg;
    logic [PIX_W-1:0]    rd_a_reg, rd_b_reg;
    logic                fwd;

    // stage 2: window update
    logic [PIX_W-1:0]    win_reg [9];
    logic [PIX_W-1:0]    ewin_reg [9];
    logic [PIX_W-1:0]    win_next [9];
    logic [PIX_W-1:0]    shf [9];
    logic [PIX_W-1:0]    top, mid, bot;
    logic                s2_valid_reg, s2_emit_reg, s2_last_reg, s2_fs_reg;
    logic [PIX_W-1:0]    s2_ms_reg;
    logic                emit2;

    // stage 3: sum
    logic [SUM_W-1:0]    sum_c, sum_reg;
    logic                s3_valid_reg, s3_emit_reg, s3_last_reg, s3_fs_reg;
    logic [PIX_W-1:0]    s3_ms_reg;

    // stage 4: divide, min/max, output
    logic [SUM_W+RECIP_W-1:0] prod;
    logic [PIX_W-1:0]    mean, min_base, max_base;
    logic [PIX_W-1:0]    run_min_reg, run_max_reg;
    logic                out_valid_reg;
    logic [PIX_W-1:0]    mean_reg, min_reg, max_reg;
    logic                last_reg;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    // the write in stage 2 lands on the same edge as this read
    assign fwd = s1_valid_reg && s1_cmd_reg.wr && (s1_cmd_reg.col == q_head.col);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_a_reg <= fwd ? rd_b_reg : lb_a[q_head.col];
            rd_b_reg <= fwd ? s1_cmd_reg.pix : lb_b[q_head.col];
            s1_cmd_reg <= q_head;
            if (s1_valid_reg && s1_cmd_reg.wr)
            begin
                lb_a[s1_cmd_reg.col] <= rd_b_reg;
                lb_b[s1_cmd_reg.col] <= s1_cmd_reg.pix;
            end
        end
    end

    always_comb
    begin
        mid = rd_b_reg;
        top = s1_cmd_reg.top_mid ? mid : rd_a_reg;
        bot = s1_cmd_reg.use_pix ? s1_cmd_reg.pix : mid;
        for (int k = 0; k < 3; k++)
        begin
            shf[k*3]     = win_reg[k*3+1];
            shf[k*3+1]   = win_reg[k*3+2];
            shf[k*3+2]   = win_reg[k*3+2];
        end
        emit2 = 1'b0;
        for (int k = 0; k < 9; k++)
        begin
            win_next[k] = win_reg[k];
        end
        if (s1_cmd_reg.tail)
        begin
            emit2 = 1'b1;
            for (int k = 0; k < 9; k++)
            begin
                win_next[k] = shf[k];
            end
        end
        else if (s1_cmd_reg.fetch)
        begin
            if (s1_cmd_reg.col == '0)
            begin
                emit2 = s1_cmd_reg.emit_j0;
                for (int k = 0; k < 3; k++)
                begin
                    win_next[k]   = top;
                    win_next[3+k] = mid;
                    win_next[6+k] = bot;
                end
            end
            else
            begin
                emit2 = 1'b1;
                for (int k = 0; k < 9; k++)
                begin
                    win_next[k] = win_reg[k];
                end
                for (int k = 0; k < 3; k++)
                begin
                    win_next[k*3]   = win_reg[k*3+1];
                    win_next[k*3+1] = win_reg[k*3+2];
                end
                win_next[2] = top;
                win_next[5] = mid;
                win_next[8] = bot;
                for (int k = 0; k < 9; k++)
                begin
                    shf[k] = win_next[k];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (adv && s1_valid_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    always_comb
    begin
        sum_c = '0;
        for (int k = 0; k < 9; k++)
        begin
            sum_c = sum_c + SUM_W'(ewin_reg[k]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 9; k++)
            begin
                ewin_reg[k] <= shf[k];
            end
            s2_last_reg <= s1_cmd_reg.tail;
            s2_ms_reg   <= s1_cmd_reg.min_start;
            sum_reg     <= sum_c;
            s3_last_reg <= s2_last_reg;
            s3_ms_reg   <= s2_ms_reg;
        end
    end

    assign prod     = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(RECIP9);
    assign mean     = prod[RECIP_SH +: PIX_W];
    assign min_base = s3_fs_reg ? s3_ms_reg : run_min_reg;
    assign max_base = s3_fs_reg ? '0 : run_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s2_emit_reg   <= 1'b0;
            s2_fs_reg     <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s3_emit_reg   <= 1'b0;
            s3_fs_reg     <= 1'b0;
            run_min_reg   <= MIN_START_RESET;
            run_max_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= !q_empty;
            s2_valid_reg <= s1_valid_reg;
            s2_emit_reg  <= s1_valid_reg && emit2;
            s2_fs_reg    <= s1_valid_reg && s1_cmd_reg.fs;
            s3_valid_reg <= s2_valid_reg;
            s3_emit_reg  <= s2_valid_reg && s2_emit_reg;
            s3_fs_reg    <= s2_valid_reg && s2_fs_reg;
            out_valid_reg <= s3_valid_reg && s3_emit_reg;
            if (s3_valid_reg && (s3_fs_reg || s3_emit_reg))
            begin
                run_min_reg <= (s3_emit_reg && mean < min_base) ? mean : min_base;
                run_max_reg <= (s3_emit_reg && mean > max_base) ? mean : max_base;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mean_reg <= mean;
            min_reg  <= (mean < min_base) ? mean : min_base;
            max_reg  <= (mean > max_base) ? mean : max_base;
            last_reg <= s3_last_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign mean_value = mean_reg;
    assign frame_min  = min_reg;
    assign frame_max  = max_reg;
    assign frame_last = last_reg;

endmodule

### rtl/box_filter_3x3_replicate.sv
// ----------------------------------------------------------------------------
// box_filter_3x3_replicate
// 3x3 mean filter with edge replication over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per beat (tdata) or a drain beat (tuser = 1).
//   Send num_rows x num_cols pixels in raster order, then num_cols + 1 drain
//   beats to flush the last row; the final result has m_axis_tlast set.
//   m_axis carries the mean plus the frame's running min and max.
//   Results trail their pixel by one row plus one pixel of input beats.
//   Throughput: one beat per cycle in both directions while m_axis_tready is high.
//   Path: the beat that completes a result passes through the queue, the line
//   buffer read, window, sum and divide/min/max output register to m_axis.
//   A 4-entry queue decouples the sequencer from the datapath; s_axis_tready
//   drops only when that queue is full, so a stalled receiver backs up the
//   pipeline and then the queue before the sender sees it.
//   Reset clears sequencer, queue, window and min/max (min back to 64);
//   line buffers are not cleared, and no result depends on unwritten ones.
//   Configure through the APB port only while the block is idle; a write to
//   num_rows or num_cols abandons the frame in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module box_filter_3x3_replicate
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] pixel_value
    input  logic        s_axis_tuser,   // [0] drain
    // result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] mean_value, [15:8] frame_min,
                                        // [23:16] frame_max
    output logic        m_axis_tlast    // frame_last
);
    import bf3_pkg::*;

    logic [SIZE_W-1:0]  num_rows_reg, num_cols_reg;
    logic [PIX_W-1:0]   min_start_reg;
    logic               cfg_wr, abandon, in_beat;
    bf3_reg_t           cfg_idx;

    logic               push, q_empty, q_full, q_pop;
    logic [QCNT_W-1:0]  q_level;
    bf3_cmd_t           cmd, q_head;
    logic [PIX_W-1:0]   mean_value, frame_min, frame_max;

    assign pready  = 1'b1;
    assign cfg_idx = bf3_reg_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    // a size change abandons the frame in progress
    assign abandon = cfg_wr && (cfg_idx == REG_NUM_ROWS || cfg_idx == REG_NUM_COLS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= SIZE_W'(1);
            num_cols_reg  <= SIZE_W'(1);
            min_start_reg <= MIN_START_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_NUM_ROWS:  num_rows_reg  <= pwdata[SIZE_W-1:0];
                REG_NUM_COLS:  num_cols_reg  <= pwdata[SIZE_W-1:0];
                REG_MIN_START: min_start_reg <= pwdata[PIX_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_NUM_ROWS:  prdata = 32'(num_rows_reg);
            REG_NUM_COLS:  prdata = 32'(num_cols_reg);
            REG_MIN_START: prdata = 32'(min_start_reg);
            default:       prdata = '0;
        endcase
    end

    // hold input beats off only while the queue is full
    assign s_axis_tready = !q_full;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    bf3_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (in_beat),
        .pixel_value (s_axis_tdata),
        .drain       (s_axis_tuser),
        .abandon     (abandon),
        .num_rows    (num_rows_reg),
        .num_cols    (num_cols_reg),
        .min_start   (min_start_reg),
        .push        (push),
        .cmd         (cmd)
    );

    bf3_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (q_pop),
        .empty    (q_empty),
        .full     (q_full),
        .level    (q_level),
        .head     (q_head)
    );

    bf3_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .mean_value (mean_value),
        .frame_min  (frame_min),
        .frame_max  (frame_max),
        .frame_last (m_axis_tlast)
    );

    assign m_axis_tdata = {frame_max, frame_min, mean_value};

    // the running extremes always bracket the result they travel with
    `BF3_ASSERT_IMP(a_mean_le_max, m_axis_tvalid, mean_value <= frame_max, "mean above frame max")
    `BF3_ASSERT_IMP(a_mean_ge_min, m_axis_tvalid, mean_value >= frame_min, "mean below frame min")
    `BF3_ASSERT_ALWAYS(a_q_level, q_level <= QCNT_W'(QDEPTH), "queue overflow")

endmodule
